>>> hdl/bhtf_pkg.sv
// Shared types, codes and constants for the boost hold timer / floor controller.
// No dependencies; imported by every module of the block.
package bhtf_pkg;

  // Fixed field widths
  localparam int unsigned TIMER_W    = 14;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned MASK_W     = 6;
  localparam int unsigned MAX_REASON = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [PCT_W-1:0] PCT_MAX        = 7'd100;
  localparam logic [PCT_W-1:0] GAME_FLOOR_PCT = 7'd62;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PULSE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Power profiles
  localparam logic [1:0] PROF_BALANCED = 2'd0;
  localparam logic [1:0] PROF_GAME     = 2'd1;
  localparam logic [1:0] PROF_BATTERY  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAME_FLAG    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_BOOST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HOOK   = 3'd6;

  // Reason carrying the input events
  localparam logic [2:0] REASON_INPUT = 3'd1;

  typedef struct packed {
    logic [1:0]       profile_mode;
    logic             game_flag;
    logic [PCT_W-1:0] base_floor_pct;
    logic [PCT_W-1:0] active_floor_pct;
    logic [PCT_W-1:0] sched_boost_level;
    logic [PCT_W-1:0] clamp_min_pct;
    logic             input_hook_en;
  } cfg_t;

  // Timer bank status after the current item's update
  typedef struct packed {
    logic [MAX_REASON-1:0] run;
    logic                  any_run;
    logic                  keep_run;
  } tmr_status_t;

  typedef struct packed {
    logic [MASK_W-1:0] active_mask;
    logic              scene_active;
    logic [PCT_W-1:0]  floor_out_pct;
    logic [PCT_W-1:0]  sched_boost_out;
    logic [PCT_W-1:0]  clamp_min_out;
  } result_t;

  // Default hold time per reason, in ms
  function automatic logic [TIMER_W-1:0] default_hold(input logic [2:0] r);
    logic [TIMER_W-1:0] v;
    unique case (r)
      3'd1:    v = 14'd96;
      3'd2:    v = 14'd280;
      3'd3:    v = 14'd220;
      3'd4:    v = 14'd220;
      default: v = 14'd180;
    endcase
    return v;
  endfunction

  // Saturate a written percent value at 100
  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

>>> hdl/bhtf_cfg_regs.sv
// Configuration register file of the boost hold timer / floor controller.
// Depends on bhtf_pkg for register indexes and the cfg_t type.
module bhtf_cfg_regs import bhtf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [PCT_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Decode a write, clamping out-of-range values
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_PROFILE_MODE: cfg_nxt.profile_mode =
          (wr_data[1:0] > PROF_BATTERY) ? PROF_BATTERY : wr_data[1:0];
        CFG_GAME_FLAG:    cfg_nxt.game_flag         = wr_data[0];
        CFG_BASE_FLOOR:   cfg_nxt.base_floor_pct    = sat_pct(wr_data);
        CFG_ACTIVE_FLOOR: cfg_nxt.active_floor_pct  = sat_pct(wr_data);
        CFG_SCHED_BOOST:  cfg_nxt.sched_boost_level = sat_pct(wr_data);
        CFG_CLAMP_MIN:    cfg_nxt.clamp_min_pct     = sat_pct(wr_data);
        CFG_INPUT_HOOK:   cfg_nxt.input_hook_en     = wr_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.profile_mode      <= PROF_BALANCED;
      cfg_r.game_flag         <= 1'b0;
      cfg_r.base_floor_pct    <= 7'd0;
      cfg_r.active_floor_pct  <= 7'd72;
      cfg_r.sched_boost_level <= 7'd12;
      cfg_r.clamp_min_pct     <= 7'd20;
      cfg_r.input_hook_en     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/bhtf_timer_bank.sv
// Bank of retriggerable one-shot hold timers, one per boost reason.
// Depends on bhtf_pkg for widths, operation codes and default hold times.
module bhtf_timer_bank import bhtf_pkg::*; #(
  parameter int unsigned NUM_REASONS = 6,
  parameter int unsigned MAX_HOLD_MS = 10000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        op,
  input  logic [2:0]        reason,
  input  logic [HOLD_W-1:0] hold_ms,
  input  logic              event_ok,
  output tmr_status_t       status
);

  localparam logic [HOLD_W-1:0] MAX_HOLD = HOLD_W'(MAX_HOLD_MS);

  logic [MAX_REASON-1:0] run;

  // Pulse duration; an input event always takes the default
  logic [HOLD_W-1:0] hold_req;
  assign hold_req = (op == OP_PULSE) ? hold_ms : '0;

  for (genvar g = 0; g < NUM_REASONS; g++) begin : g_tmr
    logic               load;
    logic [HOLD_W-1:0]  raw;
    logic [HOLD_W-1:0]  clamped;
    logic [TIMER_W-1:0] remaining_r;
    logic [TIMER_W-1:0] remaining_nxt;

    // Select the load value: default for zero, then clamp
    assign load = ((op == OP_PULSE) && (reason == 3'(g))) ||
                  ((op == OP_EVENT) && event_ok && (REASON_INPUT == 3'(g)));
    assign raw = (hold_req == '0) ? HOLD_W'(default_hold(3'(g))) : hold_req;
    assign clamped = (raw > MAX_HOLD) ? MAX_HOLD : raw;

    // Reload, count down on a tick, or hold
    always_comb begin
      remaining_nxt = remaining_r;
      if (step) begin
        if (load) begin
          remaining_nxt = clamped[TIMER_W-1:0];
        end else if ((op == OP_TICK) && (remaining_r != '0)) begin
          remaining_nxt = remaining_r - 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        remaining_r <= '0;
      end else begin
        remaining_r <= remaining_nxt;
      end
    end

    assign run[g] = (remaining_nxt != '0);
  end

  for (genvar g = NUM_REASONS; g < MAX_REASON; g++) begin : g_unused
    assign run[g] = 1'b0;
  end

  // Report state after this item's update
  assign status.run      = run;
  assign status.any_run  = |run;
  assign status.keep_run = |run[2:0];

endmodule

>>> hdl/bhtf_floor_calc.sv
// Derives the performance floor, scene flag and gated boost outputs.
// Depends on bhtf_pkg for cfg_t, tmr_status_t, result_t and profile codes.
module bhtf_floor_calc import bhtf_pkg::*; (
  input  cfg_t        cfg,
  input  tmr_status_t status,
  output result_t     res
);

  logic             game;
  logic [PCT_W-1:0] floor_game;
  logic [PCT_W-1:0] floor_act;
  logic             scene;

  assign game = (cfg.profile_mode == PROF_GAME) || cfg.game_flag;

  // Raise for game, then for any running timer
  assign floor_game = (game && (cfg.base_floor_pct < GAME_FLOOR_PCT)) ?
                      GAME_FLOOR_PCT : cfg.base_floor_pct;
  assign floor_act  = (status.any_run && (floor_game < cfg.active_floor_pct)) ?
                      cfg.active_floor_pct : floor_game;

  assign scene = status.any_run || game;

  // Drop the floor in battery profile unless a key timer runs
  assign res.floor_out_pct   = ((cfg.profile_mode == PROF_BATTERY) && !status.keep_run) ?
                               '0 : floor_act;
  assign res.active_mask     = status.run[MASK_W-1:0];
  assign res.scene_active    = scene;
  assign res.sched_boost_out = scene ? cfg.sched_boost_level : '0;
  assign res.clamp_min_out   = scene ? cfg.clamp_min_pct : '0;

endmodule

>>> hdl/boost_hold_timer_floor_ctrl.sv
// Boost hold timer and performance floor controller, top level.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; input register feeds
// the timer update and floor logic, which load the result register. in_ready is
// low only when the input register is full and the result register is stalled.
// Reset (rst_n, synchronous): timers idle, registers at defaults, pipeline empty.
module boost_hold_timer_floor_ctrl import bhtf_pkg::*; #(
  parameter int unsigned NUM_REASONS = 6,
  parameter int unsigned MAX_HOLD_MS = 10000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [2:0]           in_reason,
  input  logic [HOLD_W-1:0]    in_hold_ms,
  input  logic                 in_event_kind,
  input  logic                 in_event_nonzero,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MASK_W-1:0]    out_active_mask,
  output logic                 out_scene_active,
  output logic [PCT_W-1:0]     out_floor_out_pct,
  output logic [PCT_W-1:0]     out_sched_boost_out,
  output logic [PCT_W-1:0]     out_clamp_min_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_data
);

  cfg_t        cfg;
  tmr_status_t status;
  result_t     res;

  logic              s1_valid_r;
  logic [1:0]        op_r;
  logic [2:0]        reason_r;
  logic [HOLD_W-1:0] hold_r;
  logic              kind_r;
  logic              nz_r;
  logic              out_valid_r;
  result_t           res_r;

  logic advance;
  logic event_ok;

  // Move the held item on when the result register is free or draining
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign event_ok = cfg.input_hook_en && kind_r && nz_r;

  bhtf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bhtf_timer_bank #(
    .NUM_REASONS (NUM_REASONS),
    .MAX_HOLD_MS (MAX_HOLD_MS)
  ) u_tmr (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_valid_r && advance),
    .op       (op_r),
    .reason   (reason_r),
    .hold_ms  (hold_r),
    .event_ok (event_ok),
    .status   (status)
  );

  bhtf_floor_calc u_floor (
    .cfg    (cfg),
    .status (status),
    .res    (res)
  );

  // Capture an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_operation;
      reason_r <= in_reason;
      hold_r   <= in_hold_ms;
      kind_r   <= in_event_kind;
      nz_r     <= in_event_nonzero;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_active_mask     = res_r.active_mask;
  assign out_scene_active    = res_r.scene_active;
  assign out_floor_out_pct   = res_r.floor_out_pct;
  assign out_sched_boost_out = res_r.sched_boost_out;
  assign out_clamp_min_out   = res_r.clamp_min_out;

endmodule
